[design/sorted_priority_queue_defines.svh]
// Assertion macros for the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Concurrent assertion on the rising clock edge, muted while reset is high.
`define SPQ_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication form of the macro above.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
   `SPQ_ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[design/spq_pkg.sv]
// Package with the shared types and constants of the sorted priority queue.
package spq_pkg;

   localparam int SPQ_CAPACITY    = 16;
   localparam int SPQ_VALUE_WIDTH = 32;
   localparam int SPQ_COUNT_WIDTH = 5;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spq_status_type;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_REMOVE = 1'b1
   } spq_action_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                               insert;
      logic                               remove;
      logic signed [SPQ_VALUE_WIDTH-1:0]  value;
   } spq_cmd_type;

endpackage

[design/sorted_priority_queue.sv]
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
//
// A word is taken at every rising edge where start is high and busy is low; busy stays
// low, so one insert or remove is accepted each clock cycle. The answer appears in the next
// cycle on the rsp_ ports for exactly one cycle, flagged by rsp_strobe, and the receiver
// cannot hold it off. The values live in a row of CAPACITY cells kept in ascending order:
// on an insert every cell compares the new value with its own in parallel, and the cells
// holding larger values pass their contents one place to the right while the first of
// them takes the new value, so equal values leave in arrival order. On a remove the
// smallest value, held in the leftmost cell, is returned and every cell takes its right
// neighbor's value. A remove on an empty queue reports the empty status with a zero value,
// and an insert into a full queue is dropped and reports the full status. Every answer
// carries the count held after that word, five bits wide, so it wraps above 31. Cells need
// no clearing after reset: only cells below the held count are ever read.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic signed [SPQ_VALUE_WIDTH-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic signed [SPQ_VALUE_WIDTH-1:0]  rsp_removed_value,
   output logic [1:0]                         rsp_status,
   output logic [SPQ_COUNT_WIDTH-1:0]         rsp_entry_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic                               strobe_ff;
   logic signed [SPQ_VALUE_WIDTH-1:0]  removed_ff;
   logic signed [SPQ_VALUE_WIDTH-1:0]  removed_in;
   spq_status_type                     status_ff;
   spq_status_type                     status_in;
   logic [SPQ_COUNT_WIDTH-1:0]         entry_count_ff;

   logic accept;
   logic is_full;
   logic is_empty;
   spq_cmd_type cmd;

   logic [CAPACITY-1:0]                       cell_shift;
   logic signed [SPQ_VALUE_WIDTH-1:0]         cell_value [CAPACITY];

   // The chain finishes each word in the cycle it arrives, so it never pushes back.
   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // Only legal operations reach the cells; dropped words leave the store untouched.
   assign cmd.insert = accept && (req_action == ACTION_INSERT) && !is_full;
   assign cmd.remove = accept && (req_action == ACTION_REMOVE) && !is_empty;
   assign cmd.value  = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                               left_shift;
      logic signed [SPQ_VALUE_WIDTH-1:0]  left_value;
      logic signed [SPQ_VALUE_WIDTH-1:0]  right_value;

      if (i == 0) begin : g_first
         assign left_shift = 1'b0;
         assign left_value = req_value;
      end else begin : g_inner
         assign left_shift = cell_shift[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (count_ff > CW'(i)),
         .left_shift  (left_shift),
         .left_value  (left_value),
         .right_value (right_value),
         .shift       (cell_shift[i]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      count_in   = count_ff;
      removed_in = '0;
      status_in  = STATUS_DONE;
      if (accept) begin
         unique case (req_action)
            ACTION_INSERT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            ACTION_REMOVE: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  removed_in = cell_value[0];
                  count_in   = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      entry_count_ff <= SPQ_COUNT_WIDTH'(count_in);
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = entry_count_ff;

endmodule

[design/spq_cell.sv]
// One storage cell of the sorted chain, holding one value.
module spq_cell
   import spq_pkg::*;
(
   input  logic                               clock,
   input  spq_cmd_type                        cmd,
   input  logic                               occupied,
   input  logic                               left_shift,
   input  logic signed [SPQ_VALUE_WIDTH-1:0]  left_value,
   input  logic signed [SPQ_VALUE_WIDTH-1:0]  right_value,
   output logic                               shift,
   output logic signed [SPQ_VALUE_WIDTH-1:0]  value
);

   logic signed [SPQ_VALUE_WIDTH-1:0] value_ff;
   logic signed [SPQ_VALUE_WIDTH-1:0] value_in;

   // A cell moves right on insert when it is free or holds a larger value.
   assign shift = !occupied || (cmd.value < value_ff);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.insert && shift) begin
         value_in = left_shift ? left_value : cmd.value;
      end else if (cmd.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[design/spq_checker.sv]
// Port-level checker for the sorted priority queue and its bind to the top level.
`include "sorted_priority_queue_defines.svh"

module spq_checker
   import spq_pkg::*;
(
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic signed [SPQ_VALUE_WIDTH-1:0]  rsp_removed_value,
   input logic [1:0]                         rsp_status,
   input logic [SPQ_COUNT_WIDTH-1:0]         rsp_entry_count
);

   // Every accepted word gets exactly one answer in the following cycle.
   `SPQ_ASSERT_CLK(a_answer_follows, (start && !busy) |=> rsp_strobe, "missing answer")
   `SPQ_ASSERT_CLK(a_no_spurious, !(start && !busy) |=> !rsp_strobe, "answer without word")

   // A remove on an empty queue leaves it empty and returns zero.
   `SPQ_ASSERT_IMP(a_empty_answer, rsp_strobe && (rsp_status == STATUS_EMPTY),
      (rsp_removed_value == '0) && (rsp_entry_count == '0), "bad empty answer")

   // A dropped insert returns zero and keeps the count the last answer reported.
   `SPQ_ASSERT_IMP(a_full_answer, rsp_strobe && (rsp_status == STATUS_FULL) &&
      $past(rsp_strobe), (rsp_removed_value == '0) &&
      (rsp_entry_count == $past(rsp_entry_count)), "bad full answer")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the sorted priority queue: directed and random words, mirror check.
`timescale 1ns / 100ps

module tb_top;
   import spq_pkg::*;

   // One expected answer: the fields that the block returns for one accepted word.
   typedef struct {
      logic signed [SPQ_VALUE_WIDTH-1:0]  removed_value;
      spq_status_type                     status;
      logic [SPQ_COUNT_WIDTH-1:0]         entry_count;
   } spq_answer_type;

   // The mirror keeps its own ascending copy of the stored values. Every accepted word is
   // applied to that copy at once, and the answer it must cause is queued in arrival order.
   // The block answers every word exactly once and in order, so each strobed answer is
   // compared with the oldest queued one.
   class queue_mirror;
      logic signed [SPQ_VALUE_WIDTH-1:0] held_values[$];
      spq_answer_type                    pending_answers[$];
      int                                mismatches;

      function new();
         mismatches = 0;
      endfunction

      task report_mismatch(string what);
         $display("%0t ns  mismatch: %s", $time, what);
         mismatches++;
      endtask

      // Applies one accepted word. An insert goes after every held value that is less
      // than or equal to it, so equal values keep their arrival order.
      function void note_word(spq_action_type action, logic signed [SPQ_VALUE_WIDTH-1:0] value);
         spq_answer_type answer;
         int             slot;
         answer.removed_value = '0;
         answer.status        = STATUS_DONE;
         if (action == ACTION_INSERT) begin
            if (held_values.size() >= SPQ_CAPACITY) begin
               answer.status = STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < held_values.size() && held_values[slot] <= value)
                  slot++;
               held_values.insert(slot, value);
            end
         end else if (held_values.size() == 0) begin
            answer.status = STATUS_EMPTY;
         end else begin
            answer.removed_value = held_values.pop_front();
         end
         // The count port is only five bits wide, so the mirror keeps the same width.
         answer.entry_count = SPQ_COUNT_WIDTH'(held_values.size());
         pending_answers.push_back(answer);
      endfunction

      task check_answer(logic signed [SPQ_VALUE_WIDTH-1:0] removed_value,
                        logic [1:0] status, logic [SPQ_COUNT_WIDTH-1:0] entry_count);
         spq_answer_type want;
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("answer with no word outstanding (value %0d status %0d)",
                                      removed_value, status));
            return;
         end
         want = pending_answers.pop_front();
         if (removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value %0d, expected %0d",
                                      removed_value, want.removed_value));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
         if (entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      entry_count, want.entry_count));
      endtask
   endclass

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_action;
   logic signed [SPQ_VALUE_WIDTH-1:0]  req_value;
   logic                               rsp_strobe;
   logic signed [SPQ_VALUE_WIDTH-1:0]  rsp_removed_value;
   logic [1:0]                         rsp_status;
   logic [SPQ_COUNT_WIDTH-1:0]         rsp_entry_count;

   queue_mirror mirror;

   sorted_priority_queue #(
      .CAPACITY(SPQ_CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_removed_value(rsp_removed_value),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   // Free-running clock with a 2 ns period. All inputs start at known values.
   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_action = ACTION_INSERT;
      req_value  = '0;
      mirror     = new();
   end

   always #1 clock = ~clock;

   // Everything is sampled at the rising edge, before the block's own updates land. A word
   // accepted at this edge is noted before any answer is checked, so the mirror is never
   // behind the block even if an answer were to come back in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            mirror.note_word(spq_action_type'(req_action), req_value);
         if (rsp_strobe === 1'b1)
            mirror.check_answer(rsp_removed_value, rsp_status, rsp_entry_count);
      end
   end

   // Picks a value to insert. Small values give many equal entries, the extremes test the
   // signed ordering at both ends, and full-range values cover every bit of the field.
   function automatic logic signed [SPQ_VALUE_WIDTH-1:0] pick_value();
      logic signed [SPQ_VALUE_WIDTH-1:0] edges[6];
      edges = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE, 32'sh8000_0001, 32'sd0, -32'sd1};
      case ($urandom_range(9))
         0, 1, 2, 3: pick_value = $signed($urandom_range(8)) - 32'sd4;
         4:          pick_value = edges[$urandom_range(5)];
         default:    pick_value = $urandom;
      endcase
   endfunction

   // Sends one word. Entered and left at a falling edge. Before the word the line may sit
   // idle for a random number of cycles; then start is raised with the word's fields and
   // held until a rising edge finds busy low.
   task automatic send_word(spq_action_type action, logic signed [SPQ_VALUE_WIDTH-1:0] value,
                            int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start     <= 1'b0;
         req_value <= $urandom;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_action <= action;
      req_value  <= value;
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
   endtask

   // Main sequence: reset, a directed opening, then random words in phases of sender idling.
   initial begin
      int unsigned                       phase_idle[6];
      int unsigned                       idle_pct;
      int unsigned                       insert_pct;
      int unsigned                       segment_idle;
      int                                sent;
      int                                seg_len;
      int                                wait_cycles;
      spq_action_type                    directed_action[19];
      logic signed [SPQ_VALUE_WIDTH-1:0] directed_value[19];

      phase_idle = '{0, 63, 9, 0, 63, 9};

      // Remove on an empty queue first, then both extremes, zero, plus and minus one and
      // repeated extremes, all drained again, so the last remove empties the queue.
      directed_action = '{ACTION_REMOVE, ACTION_INSERT, ACTION_INSERT, ACTION_INSERT,
                          ACTION_INSERT, ACTION_INSERT, ACTION_INSERT, ACTION_INSERT,
                          ACTION_INSERT, ACTION_INSERT, ACTION_REMOVE, ACTION_REMOVE,
                          ACTION_REMOVE, ACTION_REMOVE, ACTION_REMOVE, ACTION_REMOVE,
                          ACTION_REMOVE, ACTION_REMOVE, ACTION_REMOVE};
      directed_value  = '{32'sh5A5A_A5A5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
                          32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 32'sd0,
                          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd0,
                          32'sd0, 32'sd0, 32'sd0};

      // Reset is held high from the start and released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < 19; i++)
         send_word(directed_action[i], directed_value[i], 0);

      // Random part. Each phase has its own idle rate, and within a phase the words come in
      // segments that lean toward filling, draining or neither, so the queue swings between
      // empty and full many times. About one segment in five runs without idling.
      for (int phase = 0; phase < 6; phase++) begin
         idle_pct = phase_idle[phase];
         sent = 0;
         while (sent < 300) begin
            seg_len = $urandom_range(60, 8);
            case ($urandom_range(2))
               0:       insert_pct = 80;
               1:       insert_pct = 25;
               default: insert_pct = 50;
            endcase
            segment_idle = ($urandom_range(4) == 0) ? 0 : idle_pct;
            repeat (seg_len) begin
               if ($urandom_range(99) < insert_pct)
                  send_word(ACTION_INSERT, pick_value(), segment_idle);
               else
                  send_word(ACTION_REMOVE, $urandom, segment_idle);
               sent++;
            end
         end
      end
      start <= 1'b0;

      // Drain: wait for every outstanding answer, with a limit, then go on through quiet cycles in
      // which any stray strobe would still be caught.
      wait_cycles = 0;
      while (mirror.pending_answers.size() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (mirror.pending_answers.size() != 0)
         mirror.report_mismatch($sformatf("%0d answers never arrived",
                                          mirror.pending_answers.size()));

      if (mirror.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
tb/tb_top.sv
